FILE: design/dive_branch_variable_select_defines.svh
// assertion macros for the diving variable select block
`ifndef DIVE_BRANCH_VARIABLE_SELECT_DEFINES_SVH
`define DIVE_BRANCH_VARIABLE_SELECT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DBVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define DBVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dbvs_pkg.sv
// types and constants shared by the diving variable select block
`timescale 1ns / 1ps

package dbvs_pkg;

	localparam int COLUMN_BITS   = 20;
	localparam int LOCK_BITS     = 16;
	localparam int FRACTION_BITS = 24;
	localparam int VALUE_BITS    = 56;
	localparam int TOL_BITS      = 24;
	localparam int DIST_BITS     = FRACTION_BITS + 11;

	localparam logic [FRACTION_BITS:0] FRAC_ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
	localparam logic [DIST_BITS-1:0]   PENALTY  = DIST_BITS'(1000);
	localparam logic [LOCK_BITS:0]     LOCKS_NONE = '1;
	localparam logic [DIST_BITS-1:0]   DIST_NONE  = '1;
	localparam logic [FRACTION_BITS-1:0] TOL_RESET = FRACTION_BITS'(17);

	typedef struct packed {
		logic [COLUMN_BITS-1:0]  column;
		logic signed [VALUE_BITS-1:0] value;
		logic [LOCK_BITS-1:0]    down_locks;
		logic [LOCK_BITS-1:0]    up_locks;
		logic                    is_binary;
		logic                    last_item;
	} in_item_t;

	typedef struct packed {
		logic [COLUMN_BITS-1:0] best_column;
		logic                   found;
		logic                   round_up;
		logic                   all_trivially_roundable;
	} out_item_t;

	// one evaluated candidate, as handed from the evaluator to the tracker
	typedef struct packed {
		logic [COLUMN_BITS-1:0] column;
		logic [LOCK_BITS-1:0]   locks;
		logic [DIST_BITS-1:0]   distance;
		logic                   go_up;
		logic                   fractional;
		logic                   locked_both;
		logic                   last_item;
	} cand_t;

endpackage

FILE: design/dbvs_cand.sv
// candidate evaluation: integrality test, rounding direction and ranked distance
`timescale 1ns / 1ps

module dbvs_cand (
	input  dbvs_pkg::in_item_t                  item,
	input  logic [dbvs_pkg::FRACTION_BITS-1:0]  tol,
	output dbvs_pkg::cand_t                     cand
);

	logic [dbvs_pkg::FRACTION_BITS-1:0] frac;
	logic [dbvs_pkg::FRACTION_BITS:0]   one_minus;
	logic [dbvs_pkg::FRACTION_BITS:0]   near_dist;
	logic [dbvs_pkg::FRACTION_BITS:0]   dir_dist;
	logic [dbvs_pkg::DIST_BITS-1:0]     dist_ext;
	logic                               at_or_above_half;
	logic                               go_up;

	assign frac             = item.value[dbvs_pkg::FRACTION_BITS-1:0];
	assign at_or_above_half = frac[dbvs_pkg::FRACTION_BITS-1];
	assign one_minus        = dbvs_pkg::FRAC_ONE - {1'b0, frac};
	assign near_dist        = at_or_above_half ? one_minus : {1'b0, frac};

	// fewer locks wins, ties go to the nearer integer (half rounds up)
	always_comb begin
		if (item.down_locks < item.up_locks) begin
			go_up = 1'b0;
		end else if (item.down_locks > item.up_locks) begin
			go_up = 1'b1;
		end else begin
			go_up = at_or_above_half;
		end
	end

	assign dir_dist = go_up ? one_minus : {1'b0, frac};
	assign dist_ext = dbvs_pkg::DIST_BITS'(dir_dist);

	always_comb begin
		cand.column      = item.column;
		cand.locks       = go_up ? item.up_locks : item.down_locks;
		cand.distance    = item.is_binary ? dist_ext : dist_ext * dbvs_pkg::PENALTY;
		cand.go_up       = go_up;
		cand.fractional  = near_dist > {1'b0, tol};
		cand.locked_both = (item.down_locks != '0) && (item.up_locks != '0);
		cand.last_item   = item.last_item;
	end

endmodule

FILE: design/dbvs_best.sv
// running best tracker and scan mode, builds the result on the last item
`timescale 1ns / 1ps

module dbvs_best (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dbvs_pkg::cand_t     cand,
	output dbvs_pkg::out_item_t result
);

	logic [dbvs_pkg::LOCK_BITS:0]     best_locks_q;
	logic [dbvs_pkg::DIST_BITS-1:0]   best_dist_q;
	logic [dbvs_pkg::COLUMN_BITS-1:0] best_col_q;
	logic                             best_up_q;
	logic                             have_best_q;
	logic                             trivial_q;

	logic [dbvs_pkg::LOCK_BITS:0]     base_locks;
	logic [dbvs_pkg::DIST_BITS-1:0]   base_dist;
	logic [dbvs_pkg::LOCK_BITS:0]     cand_locks;
	logic                             compete;
	logic                             leave_trivial;
	logic                             better;
	logic                             take;
	logic [dbvs_pkg::LOCK_BITS:0]     locks_n;
	logic [dbvs_pkg::DIST_BITS-1:0]   dist_n;
	logic [dbvs_pkg::COLUMN_BITS-1:0] col_n;
	logic                             up_n;
	logic                             have_n;
	logic                             trivial_n;

	assign compete       = cand.fractional && (trivial_q || cand.locked_both);
	assign leave_trivial = compete && trivial_q && cand.locked_both;

	// first doubly locked fractional variable starts the ranking over
	assign base_locks = leave_trivial ? dbvs_pkg::LOCKS_NONE : best_locks_q;
	assign base_dist  = leave_trivial ? dbvs_pkg::DIST_NONE  : best_dist_q;
	assign cand_locks = {1'b0, cand.locks};

	assign better = (cand_locks < base_locks) ||
			((cand_locks == base_locks) && (cand.distance < base_dist));
	assign take   = compete && better;

	assign locks_n   = take ? cand_locks    : base_locks;
	assign dist_n    = take ? cand.distance : base_dist;
	assign col_n     = take ? cand.column   : best_col_q;
	assign up_n      = take ? cand.go_up    : best_up_q;
	assign have_n    = take || have_best_q;
	assign trivial_n = leave_trivial ? 1'b0 : trivial_q;

	always_comb begin
		result.best_column             = have_n ? col_n : '0;
		result.found                   = have_n;
		result.round_up                = have_n && up_n;
		result.all_trivially_roundable = trivial_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_locks_q <= dbvs_pkg::LOCKS_NONE;
			best_dist_q  <= dbvs_pkg::DIST_NONE;
			best_col_q   <= '0;
			best_up_q    <= 1'b0;
			have_best_q  <= 1'b0;
			trivial_q    <= 1'b1;
		end else if (step) begin
			if (cand.last_item) begin
				best_locks_q <= dbvs_pkg::LOCKS_NONE;
				best_dist_q  <= dbvs_pkg::DIST_NONE;
				best_col_q   <= '0;
				best_up_q    <= 1'b0;
				have_best_q  <= 1'b0;
				trivial_q    <= 1'b1;
			end else begin
				best_locks_q <= locks_n;
				best_dist_q  <= dist_n;
				best_col_q   <= col_n;
				best_up_q    <= up_n;
				have_best_q  <= have_n;
				trivial_q    <= trivial_n;
			end
		end
	end

endmodule

FILE: design/dive_branch_variable_select.sv
// top level of the diving branch variable select block
`timescale 1ns / 1ps

// usage
//   item channel: one candidate variable per item (column, Q.24 value, lock
//   counts, binary flag, last marker), valid/ready, accepted when both high
//   result channel: one result item after each item marked last, valid/ready
//   cfg_we/cfg_wdata: writes integer_tolerance, write it only
//   while no scan is in flight
// timing
//   three register stages: input register, evaluated candidate register,
//   result register; result_valid rises once the last item has passed the
//   input and candidate registers and its result is in the result register
//   one item per cycle sustained while no last item waits on an unread
//   result, set by the single running compare and update of the best candidate
// reset
//   tolerance returns to 17, best cleared, trivial mode set, no result
// stall
//   results waiting in the output register do not hold up ordinary items;
//   the pipe only halts when a last item reaches the tracker while the
//   previous result has not been taken

module dive_branch_variable_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  dbvs_pkg::in_item_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output dbvs_pkg::out_item_t           result,
	input  logic                          cfg_we,
	input  logic [dbvs_pkg::TOL_BITS-1:0] cfg_wdata
);

	// tolerance register, low fraction bits only
	logic [dbvs_pkg::FRACTION_BITS-1:0] tol_q;

	// stage 1: raw item
	logic                 valid_s1;
	dbvs_pkg::in_item_t   item_s1;

	// stage 2: evaluated candidate
	logic                 valid_s2;
	dbvs_pkg::cand_t      cand_s2;
	dbvs_pkg::cand_t      cand_comb;

	dbvs_pkg::out_item_t  result_comb;
	logic                 stall;
	logic                 step;

	// hold the whole pipe only when a finished scan cannot hand off its result
	assign stall      = valid_s2 && cand_s2.last_item && result_valid && !result_ready;
	assign item_ready = !stall;
	assign step       = valid_s2 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= dbvs_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata[dbvs_pkg::FRACTION_BITS-1:0];
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (!stall) begin
			item_s1 <= item;
			cand_s2 <= cand_comb;
		end
	end

	dbvs_cand u_cand (
		.item (item_s1),
		.tol  (tol_q),
		.cand (cand_comb)
	);

	dbvs_best u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cand   (cand_s2),
		.result (result_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && cand_s2.last_item) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && cand_s2.last_item) begin
			result <= result_comb;
		end
	end

endmodule

FILE: design/dbvs_checker.sv
// port-level checks for the diving variable select block
`timescale 1ns / 1ps
`include "dive_branch_variable_select_defines.svh"

module dbvs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input dbvs_pkg::in_item_t            item,
	input logic                          result_valid,
	input logic                          result_ready,
	input dbvs_pkg::out_item_t           result,
	input logic                          cfg_we,
	input logic [dbvs_pkg::TOL_BITS-1:0] cfg_wdata
);

	`DBVS_ASSERT_NXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
	`DBVS_ASSERT_NXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(result), "result changed while stalled")
	`DBVS_ASSERT_IMP(a_none_is_zero, clk, arst_n, result_valid && !result.found, (result.best_column == '0) && !result.round_up, "empty result carries data")
	`DBVS_ASSERT_IMP(a_ready_only_on_full, clk, arst_n, !item_ready, result_valid && !result_ready, "input held without a waiting result")

endmodule

bind dive_branch_variable_select dbvs_checker u_dbvs_checker (.*);

FILE: verif/tb_dive_branch_variable_select.sv
// self-checking testbench for the diving branch variable select block
`timescale 1ns / 1ps

module tb_dive_branch_variable_select;

	import dbvs_pkg::*;

	localparam int RESET_CYCLES  = 6;
	// a result passes the input, candidate and result registers after its last item; this clears the pipe with margin
	localparam int DRAIN_CYCLES  = 8;
	// cycles with no item moving on either channel before the run is declared hung
	localparam int STALL_LIMIT   = 2000;
	// long result hold-off used to back the pipe up into the item channel
	localparam int PRESSURE_HOLD = 400;
	localparam int PRINT_CAP     = 100;

	localparam logic [FRACTION_BITS-1:0] FRAC_HALF = FRACTION_BITS'(1) << (FRACTION_BITS - 1);
	// what a scan reports when no fractional candidate competed
	localparam out_item_t NONE_FOUND = '{best_column: '0, found: 1'b0, round_up: 1'b0,
		all_trivially_roundable: 1'b1};

	// one row of the directed table: optional tolerance write before the item,
	// and a hand-written result where it is obvious
	typedef struct {
		bit                  cfg;
		logic [TOL_BITS-1:0] tol;
		in_item_t            it;
		bit                  pinned;
		out_item_t           want;
	} dir_row_t;

	// dut signals, all inputs known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;
	logic                cfg_we       = 1'b0;
	logic [TOL_BITS-1:0] cfg_wdata    = '0;

	// predictor copy of the tolerance register and the scan state
	logic [FRACTION_BITS-1:0] tol_q        = TOL_RESET;
	logic [LOCK_BITS:0]       pick_locks   = LOCKS_NONE;
	logic [DIST_BITS-1:0]     pick_dist    = DIST_NONE;
	logic [COLUMN_BITS-1:0]   pick_col     = '0;
	logic                     pick_up      = 1'b0;
	logic                     pick_valid   = 1'b0;
	logic                     trivial_scan = 1'b1;

	// selections still owed by the block, oldest first
	out_item_t pending_picks[$];

	// hand-written expectation that rides along with the item on offer
	logic      pin_now  = 1'b0;
	out_item_t pin_want = NONE_FOUND;

	// idling knobs, in percent of cycles, and the long hold-off request
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_request = 0;
	int stall_left    = 0;

	int items_taken  = 0;
	int results_seen = 0;
	int tol_writes   = 0;
	int errors       = 0;
	int quiet_cycles = 0;

	dive_branch_variable_select u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one line per mismatch, printing capped but every one counted
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at result %0d, %s: got %0h, expected %0h",
				results_seen, what, got, want);
	endtask

	// running selection over one scan; returns 1 when the item closes the scan
	function automatic bit track_candidate(input in_item_t c, output out_item_t res);
		logic [FRACTION_BITS-1:0] frac;
		logic [FRACTION_BITS:0]   near;
		logic [FRACTION_BITS:0]   span;
		logic [DIST_BITS-1:0]     rank;
		logic [LOCK_BITS-1:0]     locks;
		bit                       both;
		bit                       go_up;
		frac = c.value[FRACTION_BITS-1:0];
		near = (frac < FRAC_HALF) ? {1'b0, frac} : FRAC_ONE - frac;
		res  = NONE_FOUND;
		// anything within tolerance of an integer is not a candidate at all
		if (near > {1'b0, tol_q}) begin
			both = (c.down_locks != '0) && (c.up_locks != '0);
			if (trivial_scan || both) begin
				// first doubly locked variable restarts the race among locked ones only
				if (trivial_scan && both) begin
					trivial_scan = 1'b0;
					pick_locks   = LOCKS_NONE;
					pick_dist    = DIST_NONE;
				end
				// fewer locks wins the direction, ties go to the nearer integer
				if (c.down_locks < c.up_locks)
					go_up = 1'b0;
				else if (c.down_locks > c.up_locks)
					go_up = 1'b1;
				else
					go_up = (frac >= FRAC_HALF);
				if (go_up) begin
					locks = c.up_locks;
					span  = FRAC_ONE - frac;
				end else begin
					locks = c.down_locks;
					span  = {1'b0, frac};
				end
				rank = c.is_binary ? DIST_BITS'(span) : DIST_BITS'(span) * PENALTY;
				// strict compare keeps the earlier of two equal ranks
				if ({1'b0, locks} < pick_locks ||
					({1'b0, locks} == pick_locks && rank < pick_dist)) begin
					pick_col   = c.column;
					pick_locks = {1'b0, locks};
					pick_dist  = rank;
					pick_up    = go_up;
					pick_valid = 1'b1;
				end
			end
		end
		if (!c.last_item)
			return 1'b0;
		res.best_column             = pick_valid ? pick_col : '0;
		res.found                   = pick_valid;
		res.round_up                = pick_valid && pick_up;
		res.all_trivially_roundable = trivial_scan;
		// scan state goes back to its reset values, tolerance stays
		pick_locks   = LOCKS_NONE;
		pick_dist    = DIST_NONE;
		pick_col     = '0;
		pick_up      = 1'b0;
		pick_valid   = 1'b0;
		trivial_scan = 1'b1;
		return 1'b1;
	endfunction

	function automatic in_item_t make_candidate(input logic [COLUMN_BITS-1:0] col,
		input logic [VALUE_BITS-1:0] val, input logic [LOCK_BITS-1:0] dn,
		input logic [LOCK_BITS-1:0] up, input logic is_bin, input logic last);
		in_item_t c;
		c.column     = col;
		c.value      = val;
		c.down_locks = dn;
		c.up_locks   = up;
		c.is_binary  = is_bin;
		c.last_item  = last;
		return c;
	endfunction

	// lock counts weighted toward zero, small counts and the maximum
	function automatic logic [LOCK_BITS-1:0] random_locks();
		case ($urandom_range(5))
			0, 1: return '0;
			2: return LOCK_BITS'($urandom_range(1, 4));
			3: return '1;
			default: return LOCK_BITS'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_candidate(input bit last);
		in_item_t                 c;
		logic [FRACTION_BITS-1:0] f;
		case ($urandom_range(15))
			0: c.column = '0;
			1: c.column = '1;
			default: c.column = COLUMN_BITS'($urandom);
		endcase
		c.value = VALUE_BITS'({$urandom, $urandom});
		// fractions cluster on the tolerance edge (both sides of an integer) and on one half
		case ($urandom_range(9))
			0: f = tol_q + FRACTION_BITS'($urandom_range(2)) - FRACTION_BITS'(1);
			1: f = FRACTION_BITS'(0) -
				(tol_q + FRACTION_BITS'($urandom_range(2)) - FRACTION_BITS'(1));
			2: f = '0;
			3: f = FRAC_HALF + FRACTION_BITS'($urandom_range(2)) - FRACTION_BITS'(1);
			default: f = FRACTION_BITS'($urandom);
		endcase
		c.value[FRACTION_BITS-1:0] = f;
		c.down_locks = random_locks();
		// equal lock counts often, so the fraction tie-break gets exercised
		c.up_locks   = ($urandom_range(3) == 0) ? c.down_locks : random_locks();
		c.is_binary  = 1'($urandom_range(1));
		c.last_item  = last;
		return c;
	endfunction

	// offer one item after a random gap and hold it until the block takes it
	task automatic offer_candidate(input in_item_t it, input bit pin, input out_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		pin_now    <= pin;
		pin_want   <= want;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	// whole scans, mostly short, now and then up to max_len items
	task automatic run_scans(input int n_items, input int max_len);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, max_len);
			else
				len = $urandom_range(1, (max_len < 6) ? max_len : 6);
			for (int k = 0; k < len; k++)
				offer_candidate(random_candidate(k == len - 1), 1'b0, NONE_FOUND);
			sent += len;
		end
	endtask

	// tolerance only changes with the pipe empty: all results in, then the drain wait
	task automatic set_tolerance(input logic [TOL_BITS-1:0] v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_q = v[FRACTION_BITS-1:0];
		tol_writes++;
	endtask

	// result side: random ready, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (stall_request > 0) begin
			stall_left    = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// both channels sampled at the edge; prediction before checking
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				items_taken++;
				if (track_candidate(item, want))
					pending_picks.push_back(pin_now ? pin_want : want);
			end
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_picks.size() == 0) begin
					report_mismatch("result with no scan closed, column",
						32'(result.best_column), 32'(0));
				end else begin
					want = pending_picks.pop_front();
					if (result.best_column !== want.best_column)
						report_mismatch("best_column", 32'(result.best_column),
							32'(want.best_column));
					if (result.found !== want.found)
						report_mismatch("found", 32'(result.found), 32'(want.found));
					if (result.round_up !== want.round_up)
						report_mismatch("round_up", 32'(result.round_up),
							32'(want.round_up));
					if (result.all_trivially_roundable !== want.all_trivially_roundable)
						report_mismatch("all_trivially_roundable",
							32'(result.all_trivially_roundable),
							32'(want.all_trivially_roundable));
				end
			end
			// watchdog on cycles where nothing moves
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d results pending",
					STALL_LIMIT, pending_picks.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t            rows[$];
		logic [TOL_BITS-1:0] tol_pick;

		// single-item scans under the reset tolerance of 17
		// integral value
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h12345, 56'h00000003_000000, '0, '0, 1'b1, 1'b1),
			1'b1, NONE_FOUND});
		// fraction exactly at the tolerance still counts as integral
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00001, 56'h00000000_000011, '0, '0, 1'b1, 1'b1),
			1'b1, NONE_FOUND});
		// one past the tolerance, no locks, rounds down to the nearer integer
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00002, 56'h00000000_000012, '0, '0, 1'b1, 1'b1),
			1'b1, out_item_t'{20'h00002, 1'b1, 1'b0, 1'b1}});
		// negative value just under an integer, rounds up
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00003, 56'hFFFFFFFF_FFFFEE, '0, '0, 1'b1, 1'b1),
			1'b1, out_item_t'{20'h00003, 1'b1, 1'b1, 1'b1}});
		// exactly halfway with equal locks rounds up, both locked leaves trivial mode
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'hFFFFF, 56'h00000002_800000, 16'd5, 16'd5, 1'b0, 1'b1),
			1'b1, out_item_t'{20'hFFFFF, 1'b1, 1'b1, 1'b0}});
		// largest and smallest values are both near an integer
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00006, 56'h7FFFFFFF_FFFFFF, '1, '1, 1'b1, 1'b1),
			1'b1, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00007, 56'h80000000_000000, '1, '0, 1'b0, 1'b1),
			1'b1, NONE_FOUND});

		// one longer scan: trivial race, switch to locked-only, equal rank keeps the earlier
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00010, 56'h00000001_4CCCCC, 16'd0, 16'd3, 1'b1, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00011, 56'h00000001_19999A, 16'd2, 16'd0, 1'b0, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00012, 56'h00000001_600000, 16'd4, 16'd4, 1'b1, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00013, 56'h00000001_300000, 16'd0, 16'd7, 1'b1, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00014, 56'h00000001_200000, 16'd9, 16'd3, 1'b0, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00015, 56'h00000001_200000, 16'd3, 16'd9, 1'b1, 1'b0),
			1'b0, NONE_FOUND});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00016, 56'h00000001_200000, 16'd3, 16'd9, 1'b1, 1'b1),
			1'b0, NONE_FOUND});
		// maximum lock counts on both sides still beat an empty best
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'hFFFFF, 56'h00000001_123456, '1, '1, 1'b0, 1'b1),
			1'b0, NONE_FOUND});

		// zero tolerance: the smallest fraction competes, an integer does not
		rows.push_back(dir_row_t'{1'b1, 24'h000000,
			make_candidate(20'h00020, 56'h00000000_000001, '0, '0, 1'b1, 1'b1),
			1'b1, out_item_t'{20'h00020, 1'b1, 1'b0, 1'b1}});
		rows.push_back(dir_row_t'{1'b0, '0,
			make_candidate(20'h00021, 56'h00000005_000000, 16'd1, 16'd1, 1'b1, 1'b1),
			1'b1, NONE_FOUND});
		// tolerance of one half: nothing can be found
		rows.push_back(dir_row_t'{1'b1, 24'h800000,
			make_candidate(20'h00022, 56'h00000000_800000, 16'd2, 16'd2, 1'b1, 1'b1),
			1'b1, NONE_FOUND});
		// just under one half: only the exact half gets through
		rows.push_back(dir_row_t'{1'b1, 24'h7FFFFF,
			make_candidate(20'h00023, 56'h00000000_800000, 16'd2, 16'd2, 1'b0, 1'b1),
			1'b1, out_item_t'{20'h00023, 1'b1, 1'b1, 1'b0}});
		// back to the reset value, a large negative penalized value
		rows.push_back(dir_row_t'{1'b1, TOL_RESET,
			make_candidate(20'h00024, 56'hF0000000_ABCDEF, 16'd1, 16'd0, 1'b0, 1'b1),
			1'b0, NONE_FOUND});

		// reset once, released on an edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling on either side
		foreach (rows[i]) begin
			if (rows[i].cfg)
				set_tolerance(rows[i].tol);
			offer_candidate(rows[i].it, rows[i].pinned, rows[i].want);
		end

		// random scans: sender 20 / receiver 50, then swapped, then no idling,
		// each with three tolerance settings
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 50 : 0;
			recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 20 : 0;
			for (int sub = 0; sub < 3; sub++) begin
				case ($urandom_range(4))
					0: tol_pick = '0;
					1: tol_pick = TOL_RESET;
					2: tol_pick = TOL_BITS'($urandom_range(1, 255));
					3: tol_pick = TOL_BITS'($urandom_range(0, 24'h800000));
					default: tol_pick = 24'h800000;
				endcase
				set_tolerance(tol_pick);
				run_scans(200, 40);
			end
		end

		// back-pressure: receiver holds off while short scans keep coming,
		// so unread results back up and the item channel stalls
		set_tolerance(TOL_RESET);
		stall_request = PRESSURE_HOLD;
		run_scans(80, 3);

		// wait out every owed result, then the drain wait once more for strays
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d candidate items and %0d scan results over %0d tolerance writes,",
			items_taken, results_seen, tol_writes);
		$display("with idling on each side in turn, a long result hold-off and %0d mismatches",
			errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/dbvs_pkg.sv
design/dbvs_cand.sv
design/dbvs_best.sv
design/dive_branch_variable_select.sv
design/dbvs_checker.sv
verif/tb_dive_branch_variable_select.sv
